// File: rtl/glzw_pkg.sv
// glzw_pkg: shared types and constants for the GIF LZW compressor.
// Used by glzw_packer and gif_lzw_compressor. No dependencies.
`default_nettype none
package glzw_pkg;

  localparam int CODE_W = 12;
  localparam int WID_W  = 4;

  localparam logic [CODE_W-1:0] CLR_CODE    = 12'd256;
  localparam logic [CODE_W-1:0] END_CODE    = 12'd257;
  localparam logic [CODE_W-1:0] FIRST_CODE  = 12'd258;
  localparam logic [WID_W-1:0]  START_WIDTH = 4'd9;
  localparam logic [5:0]        HASH_MUL    = 6'd37;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       stream_end;
  } out_item_t;

  // command from the sequencer to the bit packer
  typedef struct packed {
    logic              load;
    logic              flush;
    logic              stop;
    logic [CODE_W-1:0] code;
    logic [WID_W-1:0]  width;
  } pk_cmd_t;

endpackage
`default_nettype wire

// File: rtl/glzw_packer.sv
// glzw_packer: LSB-first bit packer with output register.
// Depends on glzw_pkg.
`default_nettype none
module glzw_packer import glzw_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire pk_cmd_t   cmd,
  output logic           ready,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic [19:0]       acc_r, acc_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic              stop_r, stop_nxt;
  logic              vld_r, vld_nxt;
  out_item_t         dat_r, dat_nxt;
  logic              slot_free;
  logic [CODE_W-1:0] code_m;

  always_comb begin
    slot_free = !vld_r || !out_stall;
    ready     = (cnt_r < 5'd8) && slot_free;
    code_m    = cmd.code & CODE_W'((13'd1 << cmd.width) - 13'd1);
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    stop_nxt  = stop_r;
    vld_nxt   = vld_r && out_stall;
    dat_nxt   = dat_r;
    if (cmd.load && ready) begin
      acc_nxt  = acc_r | (20'(code_m) << cnt_r);
      cnt_nxt  = cnt_r + 5'(cmd.width);
      stop_nxt = cmd.stop;
    end else if (cmd.flush && ready) begin
      if (cnt_r != 5'd0) begin
        vld_nxt             = 1'b1;
        dat_nxt.packed_byte = acc_r[7:0];
        dat_nxt.stream_end  = 1'b1;
      end
      acc_nxt  = '0;
      cnt_nxt  = '0;
      stop_nxt = 1'b0;
    end else if (cnt_r >= 5'd8 && slot_free) begin
      vld_nxt             = 1'b1;
      dat_nxt.packed_byte = acc_r[7:0];
      dat_nxt.stream_end  = stop_r && (cnt_r == 5'd8);
      acc_nxt             = acc_r >> 8;
      cnt_nxt             = cnt_r - 5'd8;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      cnt_r  <= '0;
      stop_r <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      stop_r <= stop_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dat_r <= dat_nxt;
  end

  assign out_valid = vld_r;
  assign out_data  = dat_r;

endmodule
`default_nettype wire

// File: rtl/gif_lzw_compressor.sv
// gif_lzw_compressor: GIF variable-width LZW compressor, top level.
// Depends on glzw_pkg and glzw_packer.
//
//   channel | direction | payload    | handshake
//   in_     | input     | in_item_t  | in_valid / in_stall
//   out_    | output    | out_item_t | out_valid / out_stall
//
// A stream's first byte needs only the accept state; any other byte needs it, a
// bucket read, then chain entries compared one by one (a hit ends there). A miss
// adds a hand-off of the prefix code to the packer, and of the clear code if the
// table fills; a final byte adds three (prefix, stop, flush). Each hand-off waits
// while the packer holds a full byte; it drains one per cycle while not stalled.
// No clearing pass: bucket heads are checked against the entry fill count and
// the hash stored with each entry, so stale heads read as empty.
// in_stall is high while an item is in work; out_stall holds the packer and,
// through its ready, the sequencer.
// HASH_BUCKETS must be a power of two.
`default_nettype none
module gif_lzw_compressor import glzw_pkg::*; #(
  parameter int HASH_BUCKETS = 8192,
  parameter int DICT_CODES   = 4096
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam int HW = $clog2(HASH_BUCKETS);
  localparam int IW = $clog2(DICT_CODES);
  // entry: {prefix, byte, hash, link valid, link}
  localparam int EW = CODE_W + 8 + HW + 1 + IW;
  localparam logic [CODE_W-1:0] FULL_CODE = CODE_W'(DICT_CODES - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HEAD  = 3'd1;
  localparam logic [2:0] S_ENT   = 3'd2;
  localparam logic [2:0] S_MPFX  = 3'd3;
  localparam logic [2:0] S_MCLR  = 3'd4;
  localparam logic [2:0] S_FPFX  = 3'd5;
  localparam logic [2:0] S_FSTOP = 3'd6;
  localparam logic [2:0] S_FLUSH = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic              have_r, have_nxt;
  logic [CODE_W-1:0] prefix_r, prefix_nxt;
  logic [HW-1:0]     hash_r, hash_nxt;
  logic [WID_W-1:0]  width_r, width_nxt;
  logic [CODE_W-1:0] free_r, free_nxt;
  logic [IW-1:0]     count_r, count_nxt;
  logic [7:0]        b_r, b_nxt;
  logic              last_r, last_nxt;
  logic [HW-1:0]     h_r, h_nxt;
  logic              headv_r, headv_nxt;
  logic [IW-1:0]     head_r, head_nxt;
  logic [IW-1:0]     cur_r, cur_nxt;

  logic [IW-1:0]     head_mem [HASH_BUCKETS];
  logic [EW-1:0]     ent_mem  [DICT_CODES];
  logic [IW-1:0]     head_q;
  logic [EW-1:0]     ent_q;
  logic [IW-1:0]     ent_raddr;
  logic              wr_en;
  logic [EW-1:0]     ent_wdata;

  logic [HW+5:0]     h_prod;
  logic [HW-1:0]     h_calc;
  logic [CODE_W-1:0] e_prefix;
  logic [7:0]        e_byte;
  logic [HW-1:0]     e_hash;
  logic              e_nv;
  logic [IW-1:0]     e_next;

  pk_cmd_t           cmd;
  logic              pk_ready;

  assign {e_prefix, e_byte, e_hash, e_nv, e_next} = ent_q;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    h_prod    = ((HW+6)'(HASH_MUL) * (HW+6)'(hash_r)) + (HW+6)'(in_data.pixel_byte);
    h_calc    = h_prod[HW-1:0];
    ent_wdata = {prefix_r, b_r, h_r, headv_r, head_r};
  end

  always_comb begin
    state_nxt  = state_r;
    have_nxt   = have_r;
    prefix_nxt = prefix_r;
    hash_nxt   = hash_r;
    width_nxt  = width_r;
    free_nxt   = free_r;
    count_nxt  = count_r;
    b_nxt      = b_r;
    last_nxt   = last_r;
    h_nxt      = h_r;
    headv_nxt  = headv_r;
    head_nxt   = head_r;
    cur_nxt    = cur_r;
    ent_raddr  = e_next;
    wr_en      = 1'b0;
    cmd        = '0;
    cmd.width  = width_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          b_nxt    = in_data.pixel_byte;
          last_nxt = in_data.final_byte;
          if (!have_r) begin
            have_nxt   = 1'b1;
            prefix_nxt = CODE_W'(in_data.pixel_byte);
            hash_nxt   = HW'(in_data.pixel_byte);
            state_nxt  = in_data.final_byte ? S_FPFX : S_IDLE;
          end else begin
            h_nxt     = h_calc;
            state_nxt = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        ent_raddr = head_q;
        head_nxt  = head_q;
        cur_nxt   = head_q;
        if (head_q < count_r) begin
          headv_nxt = 1'b1;
          state_nxt = S_ENT;
        end else begin
          headv_nxt = 1'b0;
          state_nxt = S_MPFX;
        end
      end
      S_ENT: begin
        ent_raddr = e_next;
        if (e_hash != h_r) begin
          // stale bucket head from before the last clear
          headv_nxt = 1'b0;
          state_nxt = S_MPFX;
        end else if (e_prefix == prefix_r && e_byte == b_r) begin
          prefix_nxt = CODE_W'(cur_r) + FIRST_CODE;
          hash_nxt   = h_r;
          state_nxt  = last_r ? S_FPFX : S_IDLE;
        end else if (e_nv) begin
          cur_nxt = e_next;
        end else begin
          state_nxt = S_MPFX;
        end
      end
      S_MPFX: begin
        cmd.load  = 1'b1;
        cmd.code  = prefix_r;
        if (pk_ready) begin
          wr_en     = 1'b1;
          free_nxt  = free_r + 12'd1;
          count_nxt = count_r + IW'(1);
          if (free_r == FULL_CODE) begin
            state_nxt = S_MCLR;
          end else begin
            if ({1'b0, free_r} == (13'd1 << width_r)) width_nxt = width_r + 4'd1;
            prefix_nxt = CODE_W'(b_r);
            hash_nxt   = HW'(b_r);
            state_nxt  = last_r ? S_FPFX : S_IDLE;
          end
        end
      end
      S_MCLR: begin
        cmd.load = 1'b1;
        cmd.code = CLR_CODE;
        if (pk_ready) begin
          free_nxt   = FIRST_CODE;
          count_nxt  = '0;
          width_nxt  = START_WIDTH;
          prefix_nxt = CODE_W'(b_r);
          hash_nxt   = HW'(b_r);
          state_nxt  = last_r ? S_FPFX : S_IDLE;
        end
      end
      S_FPFX: begin
        cmd.load = 1'b1;
        cmd.code = prefix_r;
        if (pk_ready) state_nxt = S_FSTOP;
      end
      S_FSTOP: begin
        cmd.load = 1'b1;
        cmd.stop = 1'b1;
        cmd.code = END_CODE;
        if (pk_ready) state_nxt = S_FLUSH;
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        if (pk_ready) begin
          // stream done: back to reset state
          have_nxt   = 1'b0;
          prefix_nxt = '0;
          hash_nxt   = '0;
          free_nxt   = FIRST_CODE;
          count_nxt  = '0;
          width_nxt  = START_WIDTH;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      have_r   <= 1'b0;
      prefix_r <= '0;
      hash_r   <= '0;
      width_r  <= START_WIDTH;
      free_r   <= FIRST_CODE;
      count_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      have_r   <= have_nxt;
      prefix_r <= prefix_nxt;
      hash_r   <= hash_nxt;
      width_r  <= width_nxt;
      free_r   <= free_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_r     <= b_nxt;
    last_r  <= last_nxt;
    h_r     <= h_nxt;
    headv_r <= headv_nxt;
    head_r  <= head_nxt;
    cur_r   <= cur_nxt;
  end

  // bucket heads
  always_ff @(posedge clk) begin
    if (wr_en) head_mem[h_r] <= count_r;
    head_q <= head_mem[h_calc];
  end

  // dictionary entries
  always_ff @(posedge clk) begin
    if (wr_en) ent_mem[count_r] <= ent_wdata;
    ent_q <= ent_mem[ent_raddr];
  end

  glzw_packer u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .ready     (pk_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
